// ===== design/assert_macros.svh =====
// Assertion macros used by the engine design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off during reset.
`define ASSERT_SYNC(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check, also during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/lrfs_pkg.sv =====
// Types, codes and the word selection function of the rect fill serializer.
package lrfs_pkg;

  localparam int WORD_BITS = 9;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_FILL  = 3'd1;
  localparam logic [2:0] MODE_PIXEL = 3'd2;
  localparam logic [2:0] MODE_CMD   = 3'd3;
  localparam logic [2:0] MODE_DATA  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_SET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SET    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_WRITE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PIX_END_1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PIX_END_2   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PANEL_LIMIT = 3'd5;

  localparam logic [3:0] HDR_COL_CMD   = 4'd0;
  localparam logic [3:0] HDR_COL_START = 4'd1;
  localparam logic [3:0] HDR_COL_END   = 4'd2;
  localparam logic [3:0] HDR_PAGE_CMD  = 4'd3;
  localparam logic [3:0] HDR_PAGE_START = 4'd4;
  localparam logic [3:0] HDR_PAGE_END  = 4'd5;
  localparam logic [3:0] HDR_MEM_CMD   = 4'd6;
  localparam logic [3:0] STREAM_START  = 4'd7;
  localparam logic [3:0] PIXEL_WORDS   = 4'd9;
  localparam logic [3:0] RAW_WORDS     = 4'd1;

  localparam logic [1:0] TRIPLE_RG = 2'd0;
  localparam logic [1:0] TRIPLE_BR = 2'd1;
  localparam logic [1:0] TRIPLE_GB = 2'd2;

  localparam logic [4:0] PHASE_LAST = 5'(2 * WORD_BITS + 1);

  typedef struct packed {
    logic [7:0] column_set_code;
    logic [7:0] page_set_code;
    logic [7:0] memory_write_code;
    logic [7:0] pixel_end_first;
    logic [7:0] pixel_end_second;
    logic [7:0] panel_limit;
  } lrfs_cfg_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  width;
    logic [7:0]  height;
    logic [11:0] color;
    logic [7:0]  raw_byte;
  } lrfs_item_t;

  typedef struct packed {
    logic chip_select_n;
    logic serial_clock;
    logic serial_data;
    logic busy_res;
    logic rejected;
  } lrfs_result_t;

  function automatic logic [WORD_BITS-1:0] word_of(
    input logic [2:0]  mode,
    input logic [3:0]  hidx,
    input logic [1:0]  tidx,
    input logic [7:0]  scol,
    input logic [7:0]  ecol,
    input logic [7:0]  spage,
    input logic [7:0]  epage,
    input logic [11:0] color,
    input lrfs_cfg_t   cfg
  );
    logic [3:0] r;
    logic [3:0] g;
    logic [3:0] b;
    logic [WORD_BITS-1:0] w;
    r = color[11:8];
    g = color[7:4];
    b = color[3:0];
    if (mode == MODE_CMD) begin
      w = {1'b0, scol};
    end else if (mode == MODE_DATA) begin
      w = {1'b1, scol};
    end else begin
      case (hidx)
        HDR_COL_CMD:    w = {1'b0, cfg.column_set_code};
        HDR_COL_START:  w = {1'b1, scol};
        HDR_COL_END:    w = {1'b1, (mode == MODE_FILL) ? ecol : cfg.pixel_end_first};
        HDR_PAGE_CMD:   w = {1'b0, cfg.page_set_code};
        HDR_PAGE_START: w = {1'b1, spage};
        HDR_PAGE_END:   w = {1'b1, (mode == MODE_FILL) ? epage : cfg.pixel_end_second};
        HDR_MEM_CMD:    w = {1'b0, cfg.memory_write_code};
        default: begin
          if (mode == MODE_PIXEL) begin
            if (hidx == STREAM_START) w = {1'b1, color[11:4]};
            else w = {1'b1, color[3:0], 4'h0};
          end else begin
            case (tidx)
              TRIPLE_RG: w = {1'b1, r, g};
              TRIPLE_BR: w = {1'b1, b, r};
              default:   w = {1'b1, g, b};
            endcase
          end
        end
      endcase
    end
    return w;
  endfunction

endpackage

// ===== design/lrfs_if.sv =====
// Request and result channel interfaces.
interface lrfs_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  x;
  logic [7:0]  y;
  logic [7:0]  width;
  logic [7:0]  height;
  logic [11:0] color;
  logic [7:0]  raw_byte;

  modport source (output valid, kind, x, y, width, height, color, raw_byte, input ready);
  modport sink (input valid, kind, x, y, width, height, color, raw_byte, output ready);
endinterface

interface lrfs_res_if;
  logic valid;
  logic ready;
  logic chip_select_n;
  logic serial_clock;
  logic serial_data;
  logic busy_res;
  logic rejected;

  modport source (output valid, chip_select_n, serial_clock, serial_data, busy_res,
                  rejected, input ready);
  modport sink (input valid, chip_select_n, serial_clock, serial_data, busy_res,
                rejected, output ready);
endinterface

// ===== design/lrfs_cfg_regs.sv =====
// Configuration register file of the rect fill serializer.
module lrfs_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lrfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lrfs_pkg::CFG_DATA_W-1:0] cfg_data,
  output lrfs_pkg::lrfs_cfg_t            cfg
);
  import lrfs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.column_set_code   <= 8'd42;
      cfg.page_set_code     <= 8'd43;
      cfg.memory_write_code <= 8'd44;
      cfg.pixel_end_first   <= 8'd131;
      cfg.pixel_end_second  <= 8'd131;
      cfg.panel_limit       <= 8'd132;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLUMN_SET:  cfg.column_set_code   <= cfg_data;
        CFG_PAGE_SET:    cfg.page_set_code     <= cfg_data;
        CFG_MEM_WRITE:   cfg.memory_write_code <= cfg_data;
        CFG_PIX_END_1:   cfg.pixel_end_first   <= cfg_data;
        CFG_PIX_END_2:   cfg.pixel_end_second  <= cfg_data;
        CFG_PANEL_LIMIT: cfg.panel_limit       <= cfg_data;
        default: ;
      endcase
    end
  end
endmodule

// ===== design/lrfs_engine.sv =====
// Request state, word sequencer and pin generation, one beat per step.
`include "assert_macros.svh"

module lrfs_engine (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  lrfs_pkg::lrfs_item_t   item,
  input  lrfs_pkg::lrfs_cfg_t    cfg,
  output lrfs_pkg::lrfs_result_t result
);
  import lrfs_pkg::*;

  logic [2:0]           mode, mode_next;
  logic [3:0]           hidx, hidx_next;
  logic [WORD_BITS-1:0] shift, shift_next;
  logic [4:0]           phase, phase_next;
  logic [7:0]           scol, scol_next;
  logic [7:0]           ecol, ecol_next;
  logic [7:0]           spage, spage_next;
  logic [7:0]           epage, epage_next;
  logic [11:0]          fcolor, fcolor_next;
  logic [1:0]           tidx, tidx_next;
  logic [15:0]          pairs, pairs_next;
  logic                 sel, sel_next;
  logic                 clk_lv, clk_lv_next;
  logic                 data_lv, data_lv_next;

  logic       is_req;
  logic       rej;
  logic       load;
  logic [8:0] ex, ey;
  logic [7:0] ex_c, ey_c;
  logic [8:0] dx, dy;
  logic [17:0] cnt;
  logic [3:0] total;

  always_comb begin
    ex   = {1'b0, item.x} + {1'b0, item.width};
    ey   = {1'b0, item.y} + {1'b0, item.height};
    ex_c = (ex > {1'b0, cfg.panel_limit}) ? cfg.panel_limit : ex[7:0];
    ey_c = (ey > {1'b0, cfg.panel_limit}) ? cfg.panel_limit : ey[7:0];
    dx   = {1'b0, ex_c} - {1'b0, item.x} + 9'd1;
    dy   = {1'b0, ey_c} - {1'b0, item.y} + 9'd1;
    cnt  = {9'd0, dx} * {9'd0, dy};
  end

  always_comb begin
    mode_next    = mode;
    hidx_next    = hidx;
    shift_next   = shift;
    phase_next   = phase;
    scol_next    = scol;
    ecol_next    = ecol;
    spage_next   = spage;
    epage_next   = epage;
    fcolor_next  = fcolor;
    tidx_next    = tidx;
    pairs_next   = pairs;
    sel_next     = sel;
    clk_lv_next  = clk_lv;
    data_lv_next = data_lv;
    rej          = 1'b0;
    load         = 1'b0;
    total        = RAW_WORDS;
    is_req       = (item.kind >= MODE_FILL) && (item.kind <= MODE_DATA);

    if (is_req) begin
      if (mode != MODE_IDLE) begin
        rej = 1'b1;
      end else if ((item.kind <= MODE_PIXEL) &&
                   ((item.x > cfg.panel_limit) || (item.y > cfg.panel_limit))) begin
        rej = 1'b1;
      end else begin
        mode_next   = item.kind;
        hidx_next   = HDR_COL_CMD;
        tidx_next   = TRIPLE_RG;
        phase_next  = 5'd0;
        scol_next   = (item.kind >= MODE_CMD) ? item.raw_byte : item.x;
        spage_next  = item.y;
        fcolor_next = item.color;
        if (item.kind == MODE_FILL) begin
          ecol_next  = ex_c;
          epage_next = ey_c;
          pairs_next = cnt[16:1] + 16'd1;
        end
        load = 1'b1;
      end
    end else if (mode != MODE_IDLE) begin
      if (phase == 5'd0) begin
        sel_next   = 1'b0;
        phase_next = 5'd1;
      end else if (phase < PHASE_LAST) begin
        if (phase[0]) begin
          data_lv_next = shift[WORD_BITS-1];
          clk_lv_next  = 1'b1;
        end else begin
          clk_lv_next = 1'b0;
          shift_next  = {shift[WORD_BITS-2:0], 1'b0};
        end
        phase_next = phase + 5'd1;
      end else begin
        sel_next = 1'b1;
        if ((mode == MODE_FILL) && (hidx >= STREAM_START)) begin
          if (tidx >= TRIPLE_GB) begin
            tidx_next  = TRIPLE_RG;
            pairs_next = pairs - 16'd1;
            if (pairs_next == 16'd0) mode_next = MODE_IDLE;
          end else begin
            tidx_next = tidx + 2'd1;
          end
        end else begin
          if (mode == MODE_FILL) total = STREAM_START;
          else if (mode == MODE_PIXEL) total = PIXEL_WORDS;
          hidx_next = hidx + 4'd1;
          if ((mode != MODE_FILL) && (hidx_next >= total)) mode_next = MODE_IDLE;
        end
        phase_next = 5'd0;
        load       = (mode_next != MODE_IDLE);
      end
    end

    if (load) begin
      shift_next = word_of(mode_next, hidx_next, tidx_next, scol_next, ecol_next,
                           spage_next, epage_next, fcolor_next, cfg);
    end

    result.chip_select_n = sel_next;
    result.serial_clock  = clk_lv_next;
    result.serial_data   = data_lv_next;
    result.busy_res      = (mode_next != MODE_IDLE);
    result.rejected      = rej;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_IDLE;
      hidx    <= 4'd0;
      shift   <= '0;
      phase   <= 5'd0;
      scol    <= 8'd0;
      ecol    <= 8'd0;
      spage   <= 8'd0;
      epage   <= 8'd0;
      fcolor  <= 12'd0;
      tidx    <= 2'd0;
      pairs   <= 16'd0;
      sel     <= 1'b1;
      clk_lv  <= 1'b0;
      data_lv <= 1'b0;
    end else if (step) begin
      mode    <= mode_next;
      hidx    <= hidx_next;
      shift   <= shift_next;
      phase   <= phase_next;
      scol    <= scol_next;
      ecol    <= ecol_next;
      spage   <= spage_next;
      epage   <= epage_next;
      fcolor  <= fcolor_next;
      tidx    <= tidx_next;
      pairs   <= pairs_next;
      sel     <= sel_next;
      clk_lv  <= clk_lv_next;
      data_lv <= data_lv_next;
    end
  end

  `ASSERT_SYNC(a_idle_deselected, clk, rst, (mode == MODE_IDLE) |-> sel, "select low while idle")
  `ASSERT_SYNC(a_clock_in_select, clk, rst, clk_lv |-> !sel, "clock high while deselected")
  `ASSERT_SYNC(a_word_end_phase, clk, rst, $rose(sel) |-> (phase == 5'd0), "phase left set")
  `ASSERT_ALWAYS(a_phase_range, clk, rst || (phase <= PHASE_LAST), "bit phase out of range")
endmodule

// ===== design/lcd_rect_fill_serializer_unit.sv =====
// Top level of the 9-bit serial display writer with rectangle fill.
// One request or tick beat is taken per clock and each beat yields one result beat:
// a request register feeds the sequencer logic, whose pin levels, busy and reject
// flags land in a result register. The fill pixel count multiply sits between
// those two registers. The input takes a beat every cycle while the result
// register is free or being drained.
module lcd_rect_fill_serializer_unit (
  input  logic                            clk,
  input  logic                            rst,
  lrfs_req_if.sink                        req,
  lrfs_res_if.source                      res,
  input  logic                            cfg_we,
  input  logic [lrfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrfs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lrfs_pkg::*;

  lrfs_cfg_t    cfg;
  lrfs_item_t   item;
  lrfs_result_t step_res;
  lrfs_result_t out_res;
  logic         item_valid;
  logic         out_valid;
  logic         advance;

  lrfs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lrfs_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (item),
    .cfg    (cfg),
    .result (step_res)
  );

  assign advance   = item_valid && (!out_valid || res.ready);
  assign req.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.ready) begin
      item_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item.kind     <= req.kind;
      item.x        <= req.x;
      item.y        <= req.y;
      item.width    <= req.width;
      item.height   <= req.height;
      item.color    <= req.color;
      item.raw_byte <= req.raw_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_res <= step_res;
  end

  assign res.valid         = out_valid;
  assign res.chip_select_n = out_res.chip_select_n;
  assign res.serial_clock  = out_res.serial_clock;
  assign res.serial_data   = out_res.serial_data;
  assign res.busy_res      = out_res.busy_res;
  assign res.rejected      = out_res.rejected;
endmodule
